// ===== hdl/vm_instruction_step_macros.svh =====
// Assertion macros for the interpreter core.
// Used by vm_instruction_step.sv; expects clk and rst_n in scope.
`ifndef VM_INSTRUCTION_STEP_MACROS_SVH
`define VM_INSTRUCTION_STEP_MACROS_SVH
// same-cycle implication
`define VMS_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("vm_instruction_step: check failed");
// next-cycle implication
`define VMS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("vm_instruction_step: check failed");
`endif

// ===== hdl/vms_pkg.sv =====
// Shared types and codes for the interpreter core.
// No dependencies.
package vms_pkg;

  localparam int MEM_BYTES        = 4096;
  localparam int STACK_DEPTH      = 16;
  localparam int SCREEN_COLS_DEF  = 64;
  localparam int SCREEN_ROWS_DEF  = 32;
  localparam int AW               = 12;

  localparam logic [1:0] MODE_WR   = 2'd0;
  localparam logic [1:0] MODE_EXEC = 2'd1;
  localparam logic [1:0] MODE_ROW  = 2'd2;

  localparam logic [11:0] PC_LO   = 12'h200;
  localparam logic [11:0] PC_HI   = 12'hFFE;
  localparam logic [11:0] PC_HALT = 12'hFFF;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_SETI = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DN = 8'h9E;
  localparam logic [7:0] KEY_UP = 8'hA1;

  localparam logic [7:0] F_GDT  = 8'h07;
  localparam logic [7:0] F_WAIT = 8'h0A;
  localparam logic [7:0] F_SDT  = 8'h15;
  localparam logic [7:0] F_SST  = 8'h18;
  localparam logic [7:0] F_ADDI = 8'h1E;
  localparam logic [7:0] F_FONT = 8'h29;
  localparam logic [7:0] F_BCD  = 8'h33;
  localparam logic [7:0] F_ST   = 8'h55;
  localparam logic [7:0] F_LD   = 8'h65;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ROW, S_F0, S_F1, S_F2, S_RX, S_RY, S_EXE, S_VF,
    S_DMOD, S_DRD, S_DWR, S_BCD, S_BW, S_ST, S_LD, S_LW, S_DONE
  } state_t;

endpackage

// ===== hdl/vm_instruction_step.sv =====
// CHIP-8 style interpreter core: memory, registers, sequencer and frame buffer.
// Depends on vms_pkg and vm_instruction_step_macros.svh.
//
// A beat is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with out_valid. The receiver cannot stall, so
// the result must be captured in that cycle. After reset the core clears its
// 4096-byte memory, one byte a cycle, and stays busy while it does so.
// Steps per beat, from the accepting state through the result state: memory
// write and halted step go straight to the result, row read adds one frame
// buffer read. An instruction passes accept, three fetch states for the two
// memory reads, two register reads, execute and result, with a VF write
// between execute and result where VF is written. Sprite draw adds, before
// the VF write, the walk that reduces the origin into the screen (one
// subtract a cycle) and per sprite row a memory read, then a frame buffer
// read-modify-write. BCD adds its subtract steps and three writes; block
// store writes one register a cycle, block load reads then writes each one.
`include "vm_instruction_step_macros.svh"

module vm_instruction_step #(
  parameter int SCREEN_COLS = vms_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = vms_pkg::SCREEN_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_mem_addr,
  input  logic [7:0]  in_mem_data,
  input  logic [15:0] in_key_state,
  input  logic [4:0]  in_last_key,
  input  logic [7:0]  in_random_byte,
  input  logic [4:0]  in_row_index,
  output logic        out_valid,
  output logic [11:0] out_program_counter,
  output logic        out_halted,
  output logic        out_illegal_opcode,
  output logic        out_sound_active,
  output logic [63:0] out_row_bits
);

  localparam int RW = $clog2(SCREEN_ROWS);
  localparam int AW = vms_pkg::AW;

  vms_pkg::state_t state_r, state_nxt;

  // architectural state
  logic [AW-1:0] pc_r, pc_nxt;
  logic [15:0]   idx_r, idx_nxt;
  logic [3:0]    sp_r, sp_nxt;
  logic [7:0]    dt_r, dt_nxt;
  logic [7:0]    st_r, st_nxt;
  logic [7:0]    dreg_r [16];
  logic [AW-1:0] stk_mem [vms_pkg::STACK_DEPTH];
  logic [7:0]    main_mem [vms_pkg::MEM_BYTES];
  logic [63:0]   fb_mem [SCREEN_ROWS];
  logic [SCREEN_ROWS-1:0] fb_vld_r, fb_vld_nxt;

  // working registers
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [15:0]   keys_r, keys_nxt;
  logic [4:0]    last_r, last_nxt;
  logic [7:0]    rand_r, rand_nxt;
  logic [15:0]   op_r, op_nxt;
  logic [7:0]    vx_r, vx_nxt, vy_r, vy_nxt;
  logic          flag_r, flag_nxt;
  logic          ill_r, ill_nxt;
  logic          snd_r, snd_nxt;
  logic [63:0]   row_r, row_nxt;
  logic [7:0]    oxm_r, oxm_nxt, oym_r, oym_nxt;
  logic [RW-1:0] drow_r, drow_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [1:0]    hund_r, hund_nxt;
  logic [3:0]    tens_r, tens_nxt;

  // memory ports
  logic [7:0]    mem_q_r;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_we;
  logic [63:0]   fb_q_r, fb_wd;
  logic          fb_vq_r, fb_we;
  logic [RW-1:0] fb_ra;
  logic          stk_we;
  logic [3:0]    stk_wa;
  logic          dreg_we;
  logic [3:0]    dreg_wa, rd_idx;
  logic [7:0]    dreg_wd, dreg_rd;

  // decode
  logic [3:0]    top, ox, oy, on;
  logic [7:0]    nn;
  logic [AW-1:0] nnn, pc_next2, pc_skip, ptr_addr;
  logic          running, accept, key_down, draw_last;

  assign top      = op_r[15:12];
  assign ox       = op_r[11:8];
  assign oy       = op_r[7:4];
  assign on       = op_r[3:0];
  assign nn       = op_r[7:0];
  assign nnn      = op_r[11:0];
  assign pc_next2 = pc_r + AW'(2);
  assign pc_skip  = pc_r + AW'(4);
  assign ptr_addr = idx_r[AW-1:0] + AW'(cnt_r);
  assign running  = (pc_r >= vms_pkg::PC_LO) && (pc_r <= vms_pkg::PC_HI);
  assign accept   = start && !busy;
  assign key_down = (vx_r[7:4] == 4'd0) && keys_r[vx_r[3:0]];
  assign draw_last = (cnt_r == on - 4'd1);

  always_comb begin
    case (state_r)
      vms_pkg::S_RX: rd_idx = ox;
      vms_pkg::S_RY: rd_idx = (top == vms_pkg::OP_JPV) ? 4'd0 : oy;
      default:       rd_idx = cnt_r;
    endcase
  end
  assign dreg_rd = dreg_r[rd_idx];

  // sprite row: XOR in eight pixels one after another so that wrapped
  // columns landing on the same bit behave as sequential toggles
  logic [63:0] spr_row;
  logic        spr_hit;
  always_comb begin
    logic [8:0] c;
    spr_row = fb_vq_r ? fb_q_r : 64'd0;
    spr_hit = 1'b0;
    for (int j = 0; j < 8; j++) begin
      c = {1'b0, oxm_r} + 9'(j);
      if (c >= 9'(SCREEN_COLS)) begin
        c = c - 9'(SCREEN_COLS);
      end
      if (mem_q_r[7-j]) begin
        if (spr_row[c[5:0]]) begin
          spr_hit = 1'b1;
        end
        spr_row[c[5:0]] = ~spr_row[c[5:0]];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vms_pkg::S_CLEAR:
        if (clr_cnt_r == AW'(vms_pkg::MEM_BYTES - 1)) state_nxt = vms_pkg::S_IDLE;
      vms_pkg::S_IDLE:
        if (start) begin
          if (in_mode == vms_pkg::MODE_EXEC && running) state_nxt = vms_pkg::S_F0;
          else if (in_mode == vms_pkg::MODE_ROW) state_nxt = vms_pkg::S_ROW;
          else state_nxt = vms_pkg::S_DONE;
        end
      vms_pkg::S_ROW: state_nxt = vms_pkg::S_DONE;
      vms_pkg::S_F0:  state_nxt = vms_pkg::S_F1;
      vms_pkg::S_F1:  state_nxt = vms_pkg::S_F2;
      vms_pkg::S_F2:  state_nxt = vms_pkg::S_RX;
      vms_pkg::S_RX:  state_nxt = vms_pkg::S_RY;
      vms_pkg::S_RY:  state_nxt = vms_pkg::S_EXE;
      vms_pkg::S_EXE: begin
        state_nxt = vms_pkg::S_DONE;
        case (top)
          vms_pkg::OP_DRW: state_nxt = vms_pkg::S_DMOD;
          vms_pkg::OP_ALU:
            if (on == vms_pkg::ALU_ADD || on == vms_pkg::ALU_SUB || on == vms_pkg::ALU_SHR ||
                on == vms_pkg::ALU_SBN || on == vms_pkg::ALU_SHL) state_nxt = vms_pkg::S_VF;
          vms_pkg::OP_MISC:
            if (nn == vms_pkg::F_BCD) state_nxt = vms_pkg::S_BCD;
            else if (nn == vms_pkg::F_ST) state_nxt = vms_pkg::S_ST;
            else if (nn == vms_pkg::F_LD) state_nxt = vms_pkg::S_LD;
          default: state_nxt = vms_pkg::S_DONE;
        endcase
      end
      vms_pkg::S_VF: state_nxt = vms_pkg::S_DONE;
      vms_pkg::S_DMOD:
        if (oxm_r < 8'(SCREEN_COLS) && oym_r < 8'(SCREEN_ROWS))
          state_nxt = (on == 4'd0) ? vms_pkg::S_VF : vms_pkg::S_DRD;
      vms_pkg::S_DRD: state_nxt = vms_pkg::S_DWR;
      vms_pkg::S_DWR: state_nxt = draw_last ? vms_pkg::S_VF : vms_pkg::S_DRD;
      vms_pkg::S_BCD:
        if (rem_r < 8'd10) state_nxt = vms_pkg::S_BW;
      vms_pkg::S_BW:
        if (cnt_r == 4'd2) state_nxt = vms_pkg::S_DONE;
      vms_pkg::S_ST:
        if (cnt_r == ox) state_nxt = vms_pkg::S_DONE;
      vms_pkg::S_LD: state_nxt = vms_pkg::S_LW;
      vms_pkg::S_LW: state_nxt = (cnt_r == ox) ? vms_pkg::S_DONE : vms_pkg::S_LD;
      vms_pkg::S_DONE: state_nxt = vms_pkg::S_IDLE;
      default: state_nxt = vms_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    pc_nxt = pc_r; idx_nxt = idx_r; sp_nxt = sp_r; dt_nxt = dt_r; st_nxt = st_r;
    fb_vld_nxt = fb_vld_r; clr_cnt_nxt = clr_cnt_r;
    keys_nxt = keys_r; last_nxt = last_r; rand_nxt = rand_r; op_nxt = op_r;
    vx_nxt = vx_r; vy_nxt = vy_r; flag_nxt = flag_r; ill_nxt = ill_r; snd_nxt = snd_r;
    row_nxt = row_r; oxm_nxt = oxm_r; oym_nxt = oym_r; drow_nxt = drow_r;
    cnt_nxt = cnt_r; rem_nxt = rem_r; hund_nxt = hund_r; tens_nxt = tens_r;
    mem_ra = pc_r; mem_we = 1'b0; mem_wa = ptr_addr; mem_wd = dreg_rd;
    fb_ra = drow_r; fb_we = 1'b0; fb_wd = spr_row;
    stk_we = 1'b0; stk_wa = sp_r + 4'd1;
    dreg_we = 1'b0; dreg_wa = ox; dreg_wd = 8'd0;

    case (state_r)
      vms_pkg::S_CLEAR: begin
        mem_we = 1'b1; mem_wa = clr_cnt_r; mem_wd = 8'd0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      vms_pkg::S_IDLE: begin
        fb_ra = RW'(in_row_index);
        if (accept) begin
          keys_nxt = in_key_state; last_nxt = in_last_key; rand_nxt = in_random_byte;
          snd_nxt = (st_r != 8'd0);
          ill_nxt = 1'b0;
          row_nxt = 64'd0;
          if (in_mode == vms_pkg::MODE_WR) begin
            mem_we = 1'b1; mem_wa = in_mem_addr; mem_wd = in_mem_data;
          end
        end
      end
      vms_pkg::S_ROW: row_nxt = fb_vq_r ? fb_q_r : 64'd0;
      vms_pkg::S_F0: mem_ra = pc_r;
      vms_pkg::S_F1: begin
        mem_ra = pc_r + AW'(1);
        op_nxt = {op_r[7:0], mem_q_r};
        if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
        if (st_r != 8'd0) st_nxt = st_r - 8'd1;
      end
      vms_pkg::S_F2: op_nxt = {op_r[7:0], mem_q_r};
      vms_pkg::S_RX: vx_nxt = dreg_rd;
      vms_pkg::S_RY: vy_nxt = dreg_rd;
      vms_pkg::S_EXE: begin
        pc_nxt = pc_next2;
        cnt_nxt = 4'd0;
        case (top)
          vms_pkg::OP_SYS:
            if (op_r == vms_pkg::OPC_CLS) begin
              fb_vld_nxt = '0;
            end else if (op_r == vms_pkg::OPC_RET) begin
              sp_nxt = sp_r - 4'd1;
              pc_nxt = stk_mem[sp_r] + AW'(2);
            end else begin
              pc_nxt = vms_pkg::PC_HALT;
              ill_nxt = 1'b1;
            end
          vms_pkg::OP_JP: pc_nxt = nnn;
          vms_pkg::OP_CALL: begin
            sp_nxt = sp_r + 4'd1; stk_we = 1'b1; pc_nxt = nnn;
          end
          vms_pkg::OP_SEI:  if (vx_r == nn) pc_nxt = pc_skip;
          vms_pkg::OP_SNEI: if (vx_r != nn) pc_nxt = pc_skip;
          vms_pkg::OP_SER:  if (vx_r == vy_r) pc_nxt = pc_skip;
          vms_pkg::OP_SNER: if (vx_r != vy_r) pc_nxt = pc_skip;
          vms_pkg::OP_LDI:  begin dreg_we = 1'b1; dreg_wd = nn; end
          vms_pkg::OP_ADDI: begin dreg_we = 1'b1; dreg_wd = vx_r + nn; end
          vms_pkg::OP_ALU: begin
            logic [8:0] sum;
            sum = {1'b0, vx_r} + {1'b0, vy_r};
            dreg_we = 1'b1;
            case (on)
              vms_pkg::ALU_MOV: dreg_wd = vy_r;
              vms_pkg::ALU_OR:  dreg_wd = vx_r | vy_r;
              vms_pkg::ALU_AND: dreg_wd = vx_r & vy_r;
              vms_pkg::ALU_XOR: dreg_wd = vx_r ^ vy_r;
              vms_pkg::ALU_ADD: begin dreg_wd = sum[7:0]; flag_nxt = sum[8]; end
              vms_pkg::ALU_SUB: begin dreg_wd = vx_r - vy_r; flag_nxt = (vx_r >= vy_r); end
              vms_pkg::ALU_SHR: begin dreg_wd = {1'b0, vx_r[7:1]}; flag_nxt = vx_r[0]; end
              vms_pkg::ALU_SBN: begin dreg_wd = vy_r - vx_r; flag_nxt = (vy_r >= vx_r); end
              vms_pkg::ALU_SHL: begin dreg_wd = {vx_r[6:0], 1'b0}; flag_nxt = vx_r[7]; end
              default: dreg_we = 1'b0;
            endcase
          end
          vms_pkg::OP_SETI: idx_nxt = {4'd0, nnn};
          vms_pkg::OP_JPV:  pc_nxt = nnn + AW'(vy_r);
          vms_pkg::OP_RND:  begin dreg_we = 1'b1; dreg_wd = rand_r & nn; end
          vms_pkg::OP_DRW: begin
            flag_nxt = 1'b0; oxm_nxt = vx_r; oym_nxt = vy_r;
          end
          vms_pkg::OP_KEY:
            if (nn == vms_pkg::KEY_DN) pc_nxt = key_down ? pc_skip : pc_next2;
            else if (nn == vms_pkg::KEY_UP) pc_nxt = key_down ? pc_next2 : pc_skip;
          vms_pkg::OP_MISC:
            case (nn)
              vms_pkg::F_GDT: begin dreg_we = 1'b1; dreg_wd = dt_r; end
              vms_pkg::F_WAIT:
                if (last_r >= 5'd1 && last_r <= 5'd16) begin
                  dreg_we = 1'b1; dreg_wd = 8'(last_r - 5'd1);
                end else begin
                  pc_nxt = pc_r;
                end
              vms_pkg::F_SDT:  dt_nxt = vx_r;
              vms_pkg::F_SST:  st_nxt = vx_r;
              vms_pkg::F_ADDI: idx_nxt = idx_r + {8'd0, vx_r};
              vms_pkg::F_FONT: idx_nxt = {6'd0, vx_r, 2'b00} + {8'd0, vx_r};
              vms_pkg::F_BCD: begin rem_nxt = vx_r; hund_nxt = 2'd0; tens_nxt = 4'd0; end
              default: ;
            endcase
          default: ;
        endcase
      end
      vms_pkg::S_VF: begin
        dreg_we = 1'b1; dreg_wa = 4'hF; dreg_wd = {7'd0, flag_r};
      end
      vms_pkg::S_DMOD: begin
        // reduce the sprite origin into the screen, one subtract a cycle
        if (oxm_r >= 8'(SCREEN_COLS)) oxm_nxt = oxm_r - 8'(SCREEN_COLS);
        else if (oym_r >= 8'(SCREEN_ROWS)) oym_nxt = oym_r - 8'(SCREEN_ROWS);
        else drow_nxt = RW'(oym_r);
      end
      vms_pkg::S_DRD: begin
        mem_ra = ptr_addr; fb_ra = drow_r;
      end
      vms_pkg::S_DWR: begin
        fb_we = 1'b1;
        fb_vld_nxt[drow_r] = 1'b1;
        flag_nxt = flag_r | spr_hit;
        cnt_nxt = cnt_r + 4'd1;
        drow_nxt = (drow_r == RW'(SCREEN_ROWS - 1)) ? '0 : drow_r + RW'(1);
      end
      vms_pkg::S_BCD:
        if (rem_r >= 8'd100) begin
          rem_nxt = rem_r - 8'd100; hund_nxt = hund_r + 2'd1;
        end else if (rem_r >= 8'd10) begin
          rem_nxt = rem_r - 8'd10; tens_nxt = tens_r + 4'd1;
        end
      vms_pkg::S_BW: begin
        mem_we = 1'b1;
        case (cnt_r)
          4'd0:    mem_wd = {6'd0, hund_r};
          4'd1:    mem_wd = {4'd0, tens_r};
          default: mem_wd = rem_r;
        endcase
        cnt_nxt = cnt_r + 4'd1;
      end
      vms_pkg::S_ST: begin
        mem_we = 1'b1; mem_wd = dreg_rd;
        cnt_nxt = cnt_r + 4'd1;
      end
      vms_pkg::S_LD: mem_ra = ptr_addr;
      vms_pkg::S_LW: begin
        dreg_we = 1'b1; dreg_wa = cnt_r; dreg_wd = mem_q_r;
        cnt_nxt = cnt_r + 4'd1;
      end
      default: ;
    endcase
  end

  // outputs
  assign busy                = (state_r != vms_pkg::S_IDLE);
  assign out_valid           = (state_r == vms_pkg::S_DONE);
  assign out_program_counter = pc_r;
  assign out_halted          = !running;
  assign out_illegal_opcode  = ill_r;
  assign out_sound_active    = snd_r;
  assign out_row_bits        = row_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vms_pkg::S_CLEAR;
      pc_r <= vms_pkg::PC_LO; idx_r <= 16'd0; sp_r <= 4'd0;
      dt_r <= 8'd0; st_r <= 8'd0;
      fb_vld_r <= '0; clr_cnt_r <= '0;
      for (int i = 0; i < 16; i++) dreg_r[i] <= 8'd0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt; idx_r <= idx_nxt; sp_r <= sp_nxt;
      dt_r <= dt_nxt; st_r <= st_nxt;
      fb_vld_r <= fb_vld_nxt; clr_cnt_r <= clr_cnt_nxt;
      if (dreg_we) dreg_r[dreg_wa] <= dreg_wd;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    keys_r <= keys_nxt; last_r <= last_nxt; rand_r <= rand_nxt; op_r <= op_nxt;
    vx_r <= vx_nxt; vy_r <= vy_nxt; flag_r <= flag_nxt; ill_r <= ill_nxt;
    snd_r <= snd_nxt; row_r <= row_nxt; oxm_r <= oxm_nxt; oym_r <= oym_nxt;
    drow_r <= drow_nxt; cnt_r <= cnt_nxt; rem_r <= rem_nxt;
    hund_r <= hund_nxt; tens_r <= tens_nxt;
  end

  // main memory
  always_ff @(posedge clk) begin
    if (mem_we) main_mem[mem_wa] <= mem_wd;
    mem_q_r <= main_mem[mem_ra];
  end

  // frame buffer; rows without a valid bit read as blank
  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[drow_r] <= fb_wd;
    fb_q_r  <= fb_mem[fb_ra];
    fb_vq_r <= fb_vld_r[fb_ra];
  end

  // return stack
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= pc_r;
  end

  `VMS_ASSERT_NEXT(a_accept_busy, accept, busy)
  `VMS_ASSERT_NEXT(a_one_result, out_valid, !out_valid && !busy)
  `VMS_ASSERT_NOW(a_illegal_halts, out_valid && out_illegal_opcode,
                  out_program_counter == vms_pkg::PC_HALT && out_halted)

endmodule
